/* design/dmssr_pkg.sv */
// shared types, codes and the duty clamp of the dual motor speed regulator
package dmssr_pkg;

  localparam int unsigned DutyW   = 15;
  localparam int unsigned TachoW  = 12;
  localparam int unsigned QuoW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_DUTY_MIN  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DUTY_MAX  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_OFFSET    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DIVISOR   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DEADBAND  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_STEP      = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_INTERVAL  = 3'd6;

  typedef struct packed {
    logic [15:0]        offset;
    logic [TachoW-1:0]  divisor;
    logic [DutyW-1:0]   deadband;
    logic [DutyW-1:0]   step;
    logic [DutyW-1:0]   duty_min;
    logic [DutyW-1:0]   duty_max;
  } lane_cfg_t;

  function automatic logic [DutyW-1:0] clamp_duty(logic [16:0] mag,
                                                  logic [DutyW-1:0] lo,
                                                  logic [DutyW-1:0] hi);
    logic [16:0] v;
    v = mag;
    if (v < {2'b00, lo}) v = {2'b00, lo};
    if (v > {2'b00, hi}) v = {2'b00, hi};
    return v[DutyW-1:0];
  endfunction

endpackage

/* design/dmssr_lane.sv */
// one motor lane: serial speed divider, deadband compare and duty step
module dmssr_lane import dmssr_pkg::*; (
  input  logic              clk_i,
  input  logic              start_i,
  input  logic              step_i,
  input  lane_cfg_t         cfg_i,
  input  logic [TachoW-1:0] sample_i,
  input  logic [DutyW-1:0]  goal_i,
  input  logic [DutyW-1:0]  duty_i,
  output logic [DutyW-1:0]  duty_o
);

  logic [TachoW-1:0] rem_q, rem_d;
  logic [QuoW-1:0]   quo_q, quo_d;
  logic              neg_q, neg_d;

  logic signed [16:0] num;
  logic [16:0]        num_neg;
  logic [TachoW:0]    shifted, diff;
  logic               ge;

  logic signed [16:0] speed;
  logic signed [17:0] delta, db_pos, db_neg;
  logic [16:0]        up_val;
  logic [16:0]        dn_val;

  assign num     = $signed({5'b0, sample_i}) + $signed({cfg_i.offset[15], cfg_i.offset});
  assign num_neg = 17'd0 - num;

  assign shifted = {rem_q, quo_q[QuoW-1]};
  assign ge      = shifted >= {1'b0, cfg_i.divisor};
  assign diff    = shifted - {1'b0, cfg_i.divisor};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    neg_d = neg_q;
    if (start_i) begin
      neg_d = num[16];
      rem_d = '0;
      quo_d = num[16] ? num_neg[QuoW-1:0] : num[QuoW-1:0];
    end else if (step_i) begin
      rem_d = ge ? diff[TachoW-1:0] : shifted[TachoW-1:0];
      quo_d = {quo_q[QuoW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  // truncated quotient with the sign of the numerator
  assign speed  = neg_q ? $signed(17'd0 - {1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign delta  = $signed({3'b0, goal_i}) - $signed({speed[16], speed});
  assign db_pos = $signed({3'b0, cfg_i.deadband});
  assign db_neg = 18'sd0 - db_pos;

  assign up_val = {2'b00, duty_i} + {2'b00, cfg_i.step};
  assign dn_val = (duty_i >= cfg_i.step) ? {2'b00, duty_i - cfg_i.step}
                                         : {2'b00, cfg_i.step - duty_i};

  always_comb begin
    priority if (delta >= db_pos) begin
      duty_o = clamp_duty(up_val, cfg_i.duty_min, cfg_i.duty_max);
    end else if (delta < db_neg) begin
      duty_o = clamp_duty(dn_val, cfg_i.duty_min, cfg_i.duty_max);
    end else begin
      duty_o = duty_i;
    end
  end

endmodule

/* design/dual_motor_step_speed_regulator_top.sv */
// top level of the dual motor step speed regulator
//
// Input stream: one transaction per command. tuser carries the action (tick, start,
// stop) and the motor select, tdata the signed target and both tachometer samples.
// Output stream: one transaction per command with both duties, both direction bits
// and the shared running flag; tuser flags a tick that ran a regulation step.
// Configuration: plain write port, one register per index; the user must write it
// only while idle; the block does not enforce this. Start, stop, idle ticks and unused
// actions go through ST_FIN to the output register; a regulating tick first runs, in
// ST_DIV, the 16 one-bit-per-cycle restoring divider steps of both lanes side by side.
// Throughput: one command at a time; s_axis_tready is low from acceptance until
// the result is written to the output register.
// The output register frees the input side: a new command is taken while a result
// waits; if the receiver stalls, the next result is held back until the slot empties.
// Reset clears all motor state, the running flag, the interval counter, the
// configuration registers to their defaults and the output valid.
module dual_motor_step_speed_regulator_top import dmssr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [39:0]        s_axis_tdata_i,   // target_speed, tacho_first, tacho_second
  input  logic [2:0]         s_axis_tuser_i,   // action, motor
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [39:0]        m_axis_tdata_o,   // duty_first, duty_second, reverse_first,
                                               // reverse_second, running
  output logic [0:0]         m_axis_tuser_o,   // regulated
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;

  // configuration
  logic [DutyW-1:0]  duty_min_q, duty_max_q, deadband_q, step_q;
  logic [15:0]       offset_q, interval_q;
  logic [TachoW-1:0] divisor_q;
  lane_cfg_t         lane_cfg;

  // motor state
  logic [DutyW-1:0] duty_a_q, duty_a_d, duty_b_q, duty_b_d;
  logic [DutyW-1:0] goal_a_q, goal_a_d, goal_b_q, goal_b_d;
  logic             rev_a_q, rev_a_d, rev_b_q, rev_b_d, run_q, run_d;
  logic [15:0]      wait_q, wait_d;

  // captured command
  logic [1:0]       action_q;
  logic             motor_q, fire_q;
  logic [15:0]      target_q;

  // output register
  logic             m_valid_q;
  logic [39:0]      m_data_q;
  logic             m_user_q;

  logic             accept, fire, load_out, lane_step;
  logic [DutyW-1:0] lane_a_duty, lane_b_duty;
  logic [16:0]      target_neg;
  logic [15:0]      mag, iv;
  logic [DutyW-1:0] start_goal, start_duty;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign fire            = (s_axis_tuser_i[1:0] == ACT_TICK) && run_q && (wait_q == '0);
  assign load_out        = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready_i);
  assign lane_step       = (state_q == ST_DIV);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_min_q <= '0;
      duty_max_q <= 15'd1000;
      offset_q   <= '0;
      divisor_q  <= 12'd1;
      deadband_q <= 15'd10;
      step_q     <= 15'd10;
      interval_q <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DUTY_MIN: duty_min_q <= cfg_data_i[DutyW-1:0];
        REG_DUTY_MAX: duty_max_q <= cfg_data_i[DutyW-1:0];
        REG_OFFSET:   offset_q   <= cfg_data_i;
        REG_DIVISOR:  divisor_q  <= cfg_data_i[TachoW-1:0];
        REG_DEADBAND: deadband_q <= cfg_data_i[DutyW-1:0];
        REG_STEP:     step_q     <= cfg_data_i[DutyW-1:0];
        REG_INTERVAL: interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    lane_cfg.offset   = offset_q;
    lane_cfg.divisor  = (divisor_q == '0) ? 12'd1 : divisor_q;
    lane_cfg.deadband = deadband_q;
    lane_cfg.step     = step_q;
    lane_cfg.duty_min = duty_min_q;
    lane_cfg.duty_max = duty_max_q;
  end

  dmssr_lane u_lane_a (
    .clk_i    (clk_i),
    .start_i  (accept),
    .step_i   (lane_step),
    .cfg_i    (lane_cfg),
    .sample_i (s_axis_tdata_i[27:16]),
    .goal_i   (goal_a_q),
    .duty_i   (duty_a_q),
    .duty_o   (lane_a_duty)
  );

  dmssr_lane u_lane_b (
    .clk_i    (clk_i),
    .start_i  (accept),
    .step_i   (lane_step),
    .cfg_i    (lane_cfg),
    .sample_i (s_axis_tdata_i[39:28]),
    .goal_i   (goal_b_q),
    .duty_i   (duty_b_q),
    .duty_o   (lane_b_duty)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = fire ? ST_DIV : ST_FIN;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= s_axis_tuser_i[1:0];
      motor_q  <= s_axis_tuser_i[2];
      target_q <= s_axis_tdata_i[15:0];
      fire_q   <= fire;
    end
  end

  // merge of the lane results with the command
  assign target_neg = 17'd0 - {target_q[15], target_q};
  assign mag        = target_q[15] ? target_neg[15:0] : target_q;
  assign start_goal = mag[15] ? 15'h7fff : mag[DutyW-1:0];
  assign start_duty = clamp_duty({1'b0, mag}, duty_min_q, duty_max_q);
  assign iv         = (interval_q == '0) ? 16'd1 : interval_q;

  always_comb begin
    duty_a_d = duty_a_q;
    duty_b_d = duty_b_q;
    goal_a_d = goal_a_q;
    goal_b_d = goal_b_q;
    rev_a_d  = rev_a_q;
    rev_b_d  = rev_b_q;
    run_d    = run_q;
    wait_d   = wait_q;
    unique case (action_q)
      ACT_START: begin
        if (motor_q) begin
          rev_b_d  = target_q[15];
          goal_b_d = start_goal;
          duty_b_d = start_duty;
        end else begin
          rev_a_d  = target_q[15];
          goal_a_d = start_goal;
          duty_a_d = start_duty;
        end
        run_d = 1'b1;
      end
      ACT_STOP: begin
        if (motor_q) begin
          duty_b_d = '0;
          goal_b_d = '0;
        end else begin
          duty_a_d = '0;
          goal_a_d = '0;
        end
        run_d = 1'b0;
      end
      ACT_TICK: begin
        if (fire_q) begin
          if (goal_a_q != '0) duty_a_d = lane_a_duty;
          if (goal_b_q != '0) duty_b_d = lane_b_duty;
          wait_d = iv - 16'd1;
        end else if (wait_q != '0) begin
          wait_d = wait_q - 16'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_a_q <= '0;
      duty_b_q <= '0;
      goal_a_q <= '0;
      goal_b_q <= '0;
      rev_a_q  <= 1'b0;
      rev_b_q  <= 1'b0;
      run_q    <= 1'b0;
      wait_q   <= '0;
    end else if (load_out) begin
      duty_a_q <= duty_a_d;
      duty_b_q <= duty_b_d;
      goal_a_q <= goal_a_d;
      goal_b_q <= goal_b_d;
      rev_a_q  <= rev_a_d;
      rev_b_q  <= rev_b_d;
      run_q    <= run_d;
      wait_q   <= wait_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= {7'b0, run_d, rev_b_d, rev_a_d, duty_b_d, duty_a_d};
      m_user_q <= (action_q == ACT_TICK) && fire_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

/* design/dmssr_checker.sv */
// port-level checks of the dual motor step speed regulator and their binding
module dmssr_checker import dmssr_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid_i,
  input logic               s_axis_tready_o,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [39:0]        m_axis_tdata_o,
  input logic [0:0]         m_axis_tuser_o,
  input logic               cfg_we_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // one command in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while a command is in flight");

  // a regulation step only happens while running
  a_reg_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o[32])
    else $error("regulated without running flag");

  // configuration only changes while nothing is in flight
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> s_axis_tready_o && !m_axis_tvalid_o)
    else $error("configuration written while a command is in flight");

endmodule

bind dual_motor_step_speed_regulator_top dmssr_checker u_dmssr_checker (.*);

/* tb/motor_status_checker.sv */
// watches the command and status streams of the regulator, predicts each status and compares
module motor_status_checker import dmssr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  input  logic               s_axis_tready_i,
  input  logic [39:0]        s_axis_tdata_i,   // target_speed, tacho_first, tacho_second
  input  logic [2:0]         s_axis_tuser_i,   // action, motor
  input  logic               m_axis_tvalid_i,
  input  logic               m_axis_tready_i,
  input  logic [39:0]        m_axis_tdata_i,   // duty_first, duty_second, reverse_first,
                                               // reverse_second, running
  input  logic [0:0]         m_axis_tuser_i,   // regulated
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  typedef struct packed {
    logic [6:0]       pad;
    logic             running;
    logic             rev_second;
    logic             rev_first;
    logic [DutyW-1:0] duty_second;
    logic [DutyW-1:0] duty_first;
    logic             regulated;
  } motor_status_t;

  int duty_lo, duty_hi, tacho_off, tacho_div, band, duty_inc, interval;
  int duty [2];
  int goal [2];
  bit rev [2];
  bit run;
  int wait_cnt;

  motor_status_t motor_status_q [$];

  function automatic int bound_duty(int v);
    int m;
    m = (v < 0) ? -v : v;
    if (m < duty_lo) m = duty_lo;
    if (m > duty_hi) m = duty_hi;
    return m & 'h7fff;
  endfunction

  function automatic int regulate_lane(int duty_now, int goal_now, int sample);
    int dv, speed, err;
    dv = (tacho_div == 0) ? 1 : tacho_div;
    speed = (sample + tacho_off) / dv;
    err = goal_now - speed;
    if (err >= band) return bound_duty(duty_now + duty_inc);
    if (err < -band) return bound_duty(duty_now - duty_inc);
    return duty_now;
  endfunction

  function automatic motor_status_t advance_regulator(logic [2:0] user, logic [39:0] data);
    motor_status_t st;
    int target, mag, lane, iv;
    bit fired;
    fired = 1'b0;
    lane = int'(user[2]);
    case (user[1:0])
      ACT_START: begin
        target = int'($signed(data[15:0]));
        mag = (target < 0) ? -target : target;
        rev[lane] = (target < 0);
        goal[lane] = (mag > 32767) ? 32767 : mag;
        duty[lane] = bound_duty(mag);
        run = 1'b1;
      end
      ACT_STOP: begin
        duty[lane] = 0;
        goal[lane] = 0;
        run = 1'b0;
      end
      ACT_TICK: begin
        if (!run || wait_cnt != 0) begin
          if (wait_cnt != 0) wait_cnt--;
        end else begin
          iv = (interval == 0) ? 1 : interval;
          fired = 1'b1;
          if (goal[0] != 0) duty[0] = regulate_lane(duty[0], goal[0], int'(data[27:16]));
          if (goal[1] != 0) duty[1] = regulate_lane(duty[1], goal[1], int'(data[39:28]));
          wait_cnt = (iv - 1) & 'hffff;
        end
      end
      default: ;
    endcase
    st.pad = '0;
    st.running = run;
    st.rev_second = rev[1];
    st.rev_first = rev[0];
    st.duty_second = DutyW'(duty[1]);
    st.duty_first = DutyW'(duty[0]);
    st.regulated = fired;
    return st;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    motor_status_t want, got;
    if (!rst_ni) begin
      duty_lo = 0;
      duty_hi = 1000;
      tacho_off = 0;
      tacho_div = 1;
      band = 10;
      duty_inc = 10;
      interval = 1;
      duty = '{0, 0};
      goal = '{0, 0};
      rev = '{0, 0};
      run = 1'b0;
      wait_cnt = 0;
      motor_status_q.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DUTY_MIN: duty_lo = int'(cfg_data_i[DutyW-1:0]);
          REG_DUTY_MAX: duty_hi = int'(cfg_data_i[DutyW-1:0]);
          REG_OFFSET:   tacho_off = int'($signed(cfg_data_i));
          REG_DIVISOR:  tacho_div = int'(cfg_data_i[TachoW-1:0]);
          REG_DEADBAND: band = int'(cfg_data_i[DutyW-1:0]);
          REG_STEP:     duty_inc = int'(cfg_data_i[DutyW-1:0]);
          REG_INTERVAL: interval = int'(cfg_data_i);
          default: ;
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = {m_axis_tdata_i, m_axis_tuser_i};
        if (motor_status_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("unexpected status transaction: duty %0d/%0d rev %0b/%0b run %0b reg %0b",
                     got.duty_first, got.duty_second, got.rev_first, got.rev_second,
                     got.running, got.regulated);
          fail_count_o++;
        end else begin
          want = motor_status_q.pop_front();
          if (got.duty_first !== want.duty_first || got.duty_second !== want.duty_second ||
              got.rev_first !== want.rev_first || got.rev_second !== want.rev_second ||
              got.running !== want.running || got.regulated !== want.regulated ||
              got.pad !== want.pad) begin
            if (fail_count_o < 10)
              $display("status mismatch: expected duty %0d/%0d rev %0b/%0b run %0b reg %0b pad %0h, got duty %0d/%0d rev %0b/%0b run %0b reg %0b pad %0h",
                       want.duty_first, want.duty_second, want.rev_first, want.rev_second,
                       want.running, want.regulated, want.pad,
                       got.duty_first, got.duty_second, got.rev_first, got.rev_second,
                       got.running, got.regulated, got.pad);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        motor_status_q.push_back(advance_regulator(s_axis_tuser_i, s_axis_tdata_i));
      pending_o = motor_status_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// stimulus and verdict for the dual motor step speed regulator
module tb_top;
  import dmssr_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               s_tvalid;
  logic               s_axis_tready;
  logic [39:0]        s_tdata;
  logic [2:0]         s_tuser;
  logic               m_axis_tvalid;
  logic               m_tready;
  logic [39:0]        m_axis_tdata;
  logic [0:0]         m_axis_tuser;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;
  int                 pending;
  int                 fail_count;

  bit calm;
  bit hold_req;
  bit hold_done;
  int target_span;

  dual_motor_step_speed_regulator_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  motor_status_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // status receiver, with one long hold-off to back the block up
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_done = 1'b1;
      end
      m_tready <= calm || ($urandom_range(0, 99) >= 11);
    end
  end

  task automatic issue(logic [1:0] act, bit motor, int target, int t0, int t1);
    logic [39:0] data;
    data = {t1[11:0], t0[11:0], target[15:0]};
    while (!calm && $urandom_range(0, 99) < 11) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= {motor, act};
    s_tdata <= data;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic random_command();
    int r, mag, target;
    logic [15:0] raw;
    logic [1:0] act;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) begin
      raw = 16'($urandom);
      target = int'($signed(raw));
    end else begin
      mag = $urandom_range(0, target_span);
      target = $urandom_range(0, 1) ? -mag : mag;
    end
    if (r < 72) act = ACT_TICK;
    else if (r < 86) act = ACT_START;
    else if (r < 95) act = ACT_STOP;
    else act = ACT_UNUSED;
    issue(act, 1'($urandom_range(0, 1)), target, $urandom_range(0, 4095),
          $urandom_range(0, 4095));
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value[15:0];
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic configure(int dmin, int dmax, int off, int dv, int db, int stp, int ivl,
                           int span);
    settle();
    write_reg(REG_DUTY_MIN, dmin);
    write_reg(REG_DUTY_MAX, dmax);
    write_reg(REG_OFFSET, off);
    write_reg(REG_DIVISOR, dv);
    write_reg(REG_DEADBAND, db);
    write_reg(REG_STEP, stp);
    write_reg(REG_INTERVAL, ivl);
    cfg_we <= 1'b0;
    target_span = span;
  endtask

  initial begin
    rst_n = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    target_span = 1000;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default settings: deadband and step of ten, duty up to 1000
    issue(ACT_TICK, 0, 0, 0, 0);
    issue(ACT_UNUSED, 1, -1, 4095, 4095);
    issue(ACT_START, 0, 500, 0, 0);
    issue(ACT_TICK, 0, 0, 200, 0);
    issue(ACT_TICK, 0, 0, 4095, 0);
    issue(ACT_TICK, 1, 0, 495, 4095);
    issue(ACT_START, 1, -32768, 0, 0);
    issue(ACT_TICK, 0, 0, 0, 0);
    issue(ACT_START, 1, 32767, 0, 0);
    issue(ACT_START, 0, -1, 0, 0);
    issue(ACT_TICK, 0, 0, 4095, 4095);
    issue(ACT_STOP, 0, 0, 0, 0);
    issue(ACT_TICK, 0, 0, 0, 0);
    issue(ACT_START, 0, 0, 0, 0);
    issue(ACT_TICK, 0, 0, 4095, 100);
    issue(ACT_STOP, 1, 32767, 4095, 4095);
    issue(ACT_STOP, 0, -32768, 0, 0);
    issue(ACT_TICK, 1, -32768, 4095, 4095);
    issue(ACT_UNUSED, 0, 0, 0, 0);
    issue(ACT_START, 1, 1000, 0, 0);
    issue(ACT_TICK, 0, 0, 0, 990);
    issue(ACT_TICK, 0, 0, 0, 1010);

    configure(0, 32767, 0, 1, 0, 1, 1, 4000);
    repeat (190) random_command();

    configure(100, 2000, -32768, 4095, 5, 32767, 3, 100);
    repeat (190) random_command();

    // minimum above maximum, zero divisor and zero interval
    configure(500, 200, 32767, 0, 32767, 0, 0, 32767);
    repeat (150) random_command();

    configure(0, 1000, -2000, 4, 10, 50, 2, 600);
    hold_req = 1'b1;
    repeat (250) random_command();

    configure($urandom_range(0, 3000), $urandom_range(0, 32767), $urandom_range(0, 65535),
              $urandom_range(1, 4095), $urandom_range(0, 200), $urandom_range(0, 500),
              $urandom_range(1, 5), 2000);
    repeat (250) random_command();

    configure(0, 0, -50, 1, 0, 32767, 1, 500);
    calm = 1'b1;
    repeat (150) random_command();
    calm = 1'b0;

    // long interval last, so only the first running tick regulates
    configure(32767, 32767, 100, 2, 3, 20, 65535, 2000);
    repeat (150) random_command();

    settle();
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
